// ===== sv/ctd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctd_pkg
// shared types, constants and helpers of the clut texture decoder
// ----------------------------------------------------------------------------
package ctd_pkg;

	// colour mode register codes
	localparam logic [1:0] MODE_4BPP  = 2'd0;
	localparam logic [1:0] MODE_8BPP  = 2'd1;
	localparam logic [1:0] MODE_24BPP = 2'd2;
	localparam logic [1:0] MODE_32BPP = 2'd3;

	// register indexes on the configuration port
	localparam logic REG_COLOR_MODE  = 1'b0;
	localparam logic REG_PIXEL_COUNT = 1'b1;

	localparam logic [1:0]  COLOR_MODE_RESET = MODE_8BPP;
	localparam int          DEF_PALETTE_ENTRIES = 256;
	localparam int          DEF_MAX_PIXELS = 1048576;
	localparam int          COUNT_W = 21;
	localparam int          QUEUE_DEPTH = 4;

	// alpha lane of a palette entry
	localparam logic [1:0]  ALPHA_LANE = 2'd3;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_LOOKUP,
		OP_DIRECT
	} op_t;

	// one job handed from the front end to the back end
	typedef struct packed {
		op_t         op;
		logic        two_pix;
		logic [1:0]  lane;
		logic [7:0]  idx0;
		logic [7:0]  idx1;
		logic        zero0;
		logic        zero1;
		logic        last0;
		logic        last1;
		logic [31:0] rgba;
	} job_t;

	function automatic logic [7:0] double_alpha(input logic [7:0] a);
		return a[7] ? 8'hFF : {a[6:0], 1'b0};
	endfunction

	function automatic logic [7:0] swap_bits_3_4(input logic [7:0] i);
		return (i & 8'hE7) | {3'b000, i[3], 4'b0000} | {4'b0000, i[4], 3'b000};
	endfunction

endpackage

// ===== sv/ctd_front.sv =====
// ----------------------------------------------------------------------------
// ctd_front
// byte classifier: tracks palette and pixel phases and builds back-end jobs
// ----------------------------------------------------------------------------
module ctd_front #(
	parameter int PALETTE_ENTRIES = ctd_pkg::DEF_PALETTE_ENTRIES,
	parameter int MAX_PIXELS = ctd_pkg::DEF_MAX_PIXELS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         frame_start,
	input  logic [1:0]                   color_mode,
	input  logic [ctd_pkg::COUNT_W-1:0]  pixel_count,
	input  logic                         q_full,
	output logic                         push,
	output ctd_pkg::job_t                job
);

	logic [9:0]                  phase_q, phase_d, phase_c;
	logic                        in_pix_q, in_pix_d, in_pix_c;
	logic [ctd_pkg::COUNT_W-1:0] pd_q, pd_d, pd_c;
	logic [23:0]                 held_q, held_d, held_c;
	logic                        done_q, done_d, done_c;
	logic [ctd_pkg::COUNT_W-1:0] cnt, pd_p1, pd_p2;
	logic [10:0]                 phase_p1, pal_bytes;
	logic [7:0]                  entry, idx8;
	logic [1:0]                  last_phase;
	logic [23:0]                 rgb;
	logic                        push_d, accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && push_d;

	always_comb begin
		// frame start clears the frame state before the byte is handled
		phase_c  = frame_start ? 10'd0 : phase_q;
		in_pix_c = frame_start ? 1'b0 : in_pix_q;
		pd_c     = frame_start ? '0 : pd_q;
		held_c   = frame_start ? 24'd0 : held_q;
		done_c   = frame_start ? 1'b0 : done_q;

		phase_d  = phase_c;
		in_pix_d = in_pix_c;
		pd_d     = pd_c;
		held_d   = held_c;
		done_d   = done_c;
		push_d   = 1'b0;
		job      = '0;

		cnt = ({11'd0, pixel_count} > 32'(MAX_PIXELS)) ? ctd_pkg::COUNT_W'(MAX_PIXELS)
			: pixel_count;
		pd_p1 = pd_c + 1'b1;
		pd_p2 = pd_c + 2'd2;
		phase_p1 = {1'b0, phase_c} + 11'd1;
		pal_bytes = (color_mode == ctd_pkg::MODE_4BPP) ? 11'd64 : 11'd1024;
		entry = phase_c[9:2];
		idx8 = ctd_pkg::swap_bits_3_4(data_byte);
		last_phase = (color_mode == ctd_pkg::MODE_24BPP) ? 2'd2 : 2'd3;
		rgb = 24'd0;

		if ((color_mode == ctd_pkg::MODE_4BPP || color_mode == ctd_pkg::MODE_8BPP)
			&& !in_pix_c) begin
			// palette byte
			if ((color_mode == ctd_pkg::MODE_8BPP || phase_c[9:6] == 4'd0)
				&& 32'(entry) < PALETTE_ENTRIES) begin
				push_d    = 1'b1;
				job.op    = ctd_pkg::OP_WRITE;
				job.idx0  = entry;
				job.lane  = phase_c[1:0];
				job.rgba  = {24'd0, (phase_c[1:0] == ctd_pkg::ALPHA_LANE)
					? ctd_pkg::double_alpha(data_byte) : data_byte};
			end
			if (phase_p1 >= pal_bytes) begin
				in_pix_d = 1'b1;
				phase_d  = 10'd0;
			end else begin
				phase_d  = phase_p1[9:0];
			end
		end else if (done_c || pd_c >= cnt) begin
			done_d = 1'b1;
		end else begin
			case (color_mode)
				ctd_pkg::MODE_4BPP: begin
					push_d      = 1'b1;
					job.op      = ctd_pkg::OP_LOOKUP;
					job.idx0    = {4'd0, data_byte[3:0]};
					job.idx1    = {4'd0, data_byte[7:4]};
					job.last0   = (pd_p1 >= cnt);
					job.two_pix = (pd_p1 < cnt);
					job.last1   = (pd_p2 >= cnt);
					pd_d        = (pd_p1 < cnt) ? pd_p2 : pd_p1;
					done_d      = (pd_p1 >= cnt) || (pd_p2 >= cnt);
				end
				ctd_pkg::MODE_8BPP: begin
					push_d    = 1'b1;
					job.op    = ctd_pkg::OP_LOOKUP;
					job.idx0  = idx8;
					job.zero0 = !(32'(idx8) < PALETTE_ENTRIES);
					job.last0 = (pd_p1 >= cnt);
					pd_d      = pd_p1;
					done_d    = (pd_p1 >= cnt);
				end
				default: begin
					if (phase_c < {8'd0, last_phase}) begin
						case (phase_c[1:0])
							2'd0:    held_d[7:0]   = data_byte;
							2'd1:    held_d[15:8]  = data_byte;
							2'd2:    held_d[23:16] = data_byte;
							default: held_d        = held_c;
						endcase
						phase_d = phase_p1[9:0];
					end else begin
						push_d    = 1'b1;
						job.op    = ctd_pkg::OP_DIRECT;
						job.last0 = (pd_p1 >= cnt);
						if (color_mode == ctd_pkg::MODE_24BPP) begin
							rgb      = {data_byte, held_c[15:0]};
							job.rgba = {(rgb == 24'd0) ? 8'h00 : 8'hFF, rgb};
						end else begin
							job.rgba = {ctd_pkg::double_alpha(data_byte), held_c};
						end
						pd_d    = pd_p1;
						done_d  = (pd_p1 >= cnt);
						phase_d = 10'd0;
						held_d  = 24'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 10'd0;
			in_pix_q <= 1'b0;
			pd_q     <= '0;
			held_q   <= 24'd0;
			done_q   <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			in_pix_q <= in_pix_d;
			pd_q     <= pd_d;
			held_q   <= held_d;
			done_q   <= done_d;
		end
	end

endmodule

// ===== sv/ctd_queue.sv =====
// ----------------------------------------------------------------------------
// ctd_queue
// short job queue between the front end and the back end
// ----------------------------------------------------------------------------
module ctd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ctd_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output ctd_pkg::job_t head_job
);

	localparam int PTR_W = $clog2(ctd_pkg::QUEUE_DEPTH);

	ctd_pkg::job_t   slots_q [ctd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full       = (count_q == (PTR_W+1)'(ctd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == ctd_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == ctd_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ctd_back.sv =====
// ----------------------------------------------------------------------------
// ctd_back
// job executor: palette memory, lookup stage and output register
// ----------------------------------------------------------------------------
module ctd_back #(
	parameter int PALETTE_ENTRIES = ctd_pkg::DEF_PALETTE_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  ctd_pkg::job_t head_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue,
	output logic [7:0]    alpha,
	output logic          last_pixel
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	logic [3:0][7:0] palette [PALETTE_ENTRIES];

	logic            sub_q;
	logic            valid_s1, lookup_s1, zero_s1, last_s1;
	logic [31:0]     rgba_s1, rd_data_s1;
	logic            out_valid_q, last_q;
	logic [31:0]     rgba_q;
	logic            en, take, wr_en, rd_en, second;
	logic [7:0]      rd_idx;
	logic            rd_zero, rd_last;

	assign en     = !out_valid_q || !out_stall;
	assign take   = en && head_valid;
	assign second = head_job.two_pix && sub_q;
	assign rd_idx = second ? head_job.idx1 : head_job.idx0;
	assign rd_zero = second ? head_job.zero1 : head_job.zero0;
	assign rd_last = second ? head_job.last1 : head_job.last0;
	assign wr_en  = take && (head_job.op == ctd_pkg::OP_WRITE);
	assign rd_en  = take && (head_job.op == ctd_pkg::OP_LOOKUP) && !rd_zero;
	// a two-pixel lookup stays at the head for its first pixel
	assign pop    = take && !(head_job.op == ctd_pkg::OP_LOOKUP
		&& head_job.two_pix && !sub_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			palette[head_job.idx0[AW-1:0]][head_job.lane] <= head_job.rgba[7:0];
		end
		if (rd_en) begin
			rd_data_s1 <= palette[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lookup_s1 <= (head_job.op == ctd_pkg::OP_LOOKUP);
			zero_s1   <= rd_zero;
			last_s1   <= rd_last;
			rgba_s1   <= head_job.rgba;
		end
		if (en) begin
			rgba_q <= lookup_s1 ? (zero_s1 ? 32'd0 : rd_data_s1) : rgba_s1;
			last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= take && (head_job.op != ctd_pkg::OP_WRITE);
			out_valid_q <= valid_s1;
			if (take && head_job.op == ctd_pkg::OP_LOOKUP && head_job.two_pix) begin
				sub_q <= !sub_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = rgba_q[7:0];
	assign green      = rgba_q[15:8];
	assign blue       = rgba_q[23:16];
	assign alpha      = rgba_q[31:24];
	assign last_pixel = last_q;

endmodule

// ===== sv/clut_texture_to_rgba_decoder.sv =====
// ----------------------------------------------------------------------------
// clut_texture_to_rgba_decoder
// palettized and direct-colour texture payload to rgba pixel decoder
// ----------------------------------------------------------------------------
// Feed the texture payload (after the header) one byte per transaction,
// with frame_start on the first byte of each texture. In the indexed modes
// the first 64 (4bpp) or 1024 (8bpp) bytes load the palette in r,g,b,a order,
// alpha doubled and clamped; later bytes index it. Direct modes take three
// (24bpp) or four (32bpp) bytes per pixel. Each pixel leaves as an rgba
// transaction, last_pixel marking the final pixel of the base image; bytes
// past it are dropped. Set color_mode and pixel_count over the apb port while
// the block is idle. A byte is accepted every cycle unless the job queue is
// full. A 4bpp byte yields two pixels; the back end looks up one pixel per
// cycle while the output is not stalled, through its single palette read
// port, so a 4bpp job stays at the queue head while its first pixel is read. A
// four-entry job queue lets the byte side keep accepting while the pixel
// side is stalled, and the output register holds a finished pixel meanwhile.
// A byte passes the queue slot, the lookup stage and the output register.
// ----------------------------------------------------------------------------
module clut_texture_to_rgba_decoder #(
	parameter int PALETTE_ENTRIES = ctd_pkg::DEF_PALETTE_ENTRIES,
	parameter int MAX_PIXELS = ctd_pkg::DEF_MAX_PIXELS
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	// pixel output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last_pixel
);

	logic [1:0]                  color_mode_q;
	logic [ctd_pkg::COUNT_W-1:0] pixel_count_q;
	logic                        cfg_wr;

	logic          push, q_full, pop, head_valid;
	ctd_pkg::job_t push_job, head_job;

	// registers decoded on address bit 2 only, byte offsets are ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q  <= ctd_pkg::COLOR_MODE_RESET;
			pixel_count_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				ctd_pkg::REG_COLOR_MODE:  color_mode_q  <= pwdata[1:0];
				ctd_pkg::REG_PIXEL_COUNT: pixel_count_q <= pwdata[ctd_pkg::COUNT_W-1:0];
				default:                  color_mode_q  <= color_mode_q;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (paddr[2])
			ctd_pkg::REG_COLOR_MODE:  prdata = {30'd0, color_mode_q};
			ctd_pkg::REG_PIXEL_COUNT: prdata = {(32 - ctd_pkg::COUNT_W)'(0), pixel_count_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// front end: classifies bytes, tracks the frame and queues jobs
	ctd_front #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES),
		.MAX_PIXELS      (MAX_PIXELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.color_mode  (color_mode_q),
		.pixel_count (pixel_count_q),
		.q_full      (q_full),
		.push        (push),
		.job         (push_job)
	);

	// job queue decoupling the two sides
	ctd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// back end: palette writes, lookups and pixel output
	ctd_back #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel)
	);

endmodule
